FILE: hw/rtl/blt_pkg.sv
// Package: shared constants, types and tables for the bearing line triangulator.
`default_nettype none
package blt_pkg;

   localparam int COORD_FRAC_BITS_DEF = 8;
   localparam int ANGLE_BITS_DEF      = 16;
   localparam int COORD_W             = 17;
   localparam int BEARING_W           = 16;
   localparam int BOX_W               = 16;
   localparam int LIMIT_W             = 8;
   localparam int TRIG_W              = 18;   // sine and cosine, scale 2^16, signed
   localparam int MUL_W               = 36;   // second multiplier operand, signed
   localparam int CORDIC_ITERS        = 16;
   localparam int ZW                  = 33;   // residual angle, 2^-32 turn, signed
   localparam int WIDE_W              = 80;   // products and numerators
   localparam int QUOT_W              = 64;   // division result range
   localparam int CSR_ADDR_W          = 2;
   localparam int CNT_W               = 7;

   localparam logic [CSR_ADDR_W-1:0] CSR_BOX_MIN   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BOX_MAX   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RES_LIMIT = 2'd2;

   localparam logic [BOX_W-1:0]   BOX_MIN_RST   = 16'd256;
   localparam logic [BOX_W-1:0]   BOX_MAX_RST   = 16'd51200;
   localparam logic [LIMIT_W-1:0] RES_LIMIT_RST = 8'd26;
   localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 18'sd39797;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,      // capture the new pose, start the CORDIC on the current bearing
      OP_CORDIC,    // one CORDIC iteration
      OP_TRIG1,     // store current sine and cosine, restart on the previous bearing
      OP_TRIG2,     // store previous sine and cosine
      OP_MUL,       // one product of the multiply schedule
      OP_DIV_X,     // start division for X
      OP_DIV_Y,     // start division for Y
      OP_DIV_STEP,  // one quotient bit
      OP_DIV_DONE_X,
      OP_DIV_DONE_Y,
      OP_DECIDE     // box, residual, latch
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic [CNT_W-1:0] step;
   } dp_cmd_type;

   typedef struct packed {
      logic det_zero;
      logic box_ok;
   } dp_status_type;

   function automatic logic [31:0] atan_turn(input logic [3:0] i);
      logic [31:0] v;
      begin
         unique case (i)
            4'd0:  v = 32'd536870912;
            4'd1:  v = 32'd316933406;
            4'd2:  v = 32'd167458907;
            4'd3:  v = 32'd85004756;
            4'd4:  v = 32'd42667331;
            4'd5:  v = 32'd21354465;
            4'd6:  v = 32'd10679838;
            4'd7:  v = 32'd5340245;
            4'd8:  v = 32'd2670163;
            4'd9:  v = 32'd1335087;
            4'd10: v = 32'd667544;
            4'd11: v = 32'd333772;
            4'd12: v = 32'd166886;
            4'd13: v = 32'd83443;
            4'd14: v = 32'd41722;
            default: v = 32'd20861;
         endcase
         return v;
      end
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bearing_line_triangulator_top.sv
// Top level: bearing line triangulator with stream ports and register port.
`default_nettype none
// Each request transaction carries an observer pose (x, y in signed Q9.8, bearing
// as a fraction of a turn). The block intersects its bearing line with that of
// the previous pose and, if the point lies in the box and both residuals stay
// below the limit, latches it as the victim position and sets the sticky found
// flag. One response transaction follows each request. Each item passes through
// two 16-step CORDIC passes on one shared rotator, fourteen sequential products
// on one multiplier and two 80-step restoring divisions on one shared divider;
// parallel lines skip the divisions and the residual products. Register writes
// are taken at any time but must only be issued while the block is idle.
module bearing_line_triangulator_top
   import blt_pkg::*;
#(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
   parameter int ANGLE_BITS      = ANGLE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [55:0]           req_tdata,  // pose_x[16:0], pose_y[33:17], bearing[49:34]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [39:0]                rsp_tdata,  // found[0], victim_x[17:1], victim_y[34:18]
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [BOX_W-1:0]      csr_data
);
   logic [BOX_W-1:0]   box_min_ff, box_max_ff;
   logic [LIMIT_W-1:0] lim_ff;
   dp_cmd_type         cmd;
   dp_status_type      status;
   logic               found;
   logic signed [COORD_W-1:0] vx, vy;

   assign csr_ready = 1'b1;

   // register writes: unknown index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_ff <= BOX_MIN_RST;
         box_max_ff <= BOX_MAX_RST;
         lim_ff     <= RES_LIMIT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BOX_MIN:   box_min_ff <= csr_data;
            CSR_BOX_MAX:   box_max_ff <= csr_data;
            CSR_RES_LIMIT: lim_ff     <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   blt_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .cmd, .status
   );

   blt_datapath #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_dp (
      .clock, .reset, .cmd, .status,
      .pose_x(req_tdata[16:0]), .pose_y(req_tdata[33:17]), .bearing(req_tdata[49:34]),
      .box_min(box_min_ff), .box_max(box_max_ff), .residual_limit(lim_ff),
      .found, .victim_x(vx), .victim_y(vy)
   );

   assign rsp_tdata = {5'd0, vy, vx, found};
endmodule
`default_nettype wire

FILE: hw/rtl/blt_datapath.sv
// Datapath: CORDIC, multiply schedule, serial divider, box and residual test.
`default_nettype none
module blt_datapath
   import blt_pkg::*;
#(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
   parameter int ANGLE_BITS      = ANGLE_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dp_cmd_type                  cmd,
   output dp_status_type                    status,
   input  wire logic signed [COORD_W-1:0]   pose_x,
   input  wire logic signed [COORD_W-1:0]   pose_y,
   input  wire logic [BEARING_W-1:0]        bearing,
   input  wire logic [BOX_W-1:0]            box_min,
   input  wire logic [BOX_W-1:0]            box_max,
   input  wire logic [LIMIT_W-1:0]          residual_limit,
   output logic                             found,
   output logic signed [COORD_W-1:0]        victim_x,
   output logic signed [COORD_W-1:0]        victim_y
);
   localparam int SHIFT_L = 32 - ANGLE_BITS;
   localparam int PROD_W  = TRIG_W + MUL_W;
   localparam logic signed [COORD_W-1:0] M10 =
      ((10 << COORD_FRAC_BITS) > 65536) ? -(COORD_W'(65536))
                                        : -(COORD_W'(10 << COORD_FRAC_BITS));
   localparam logic signed [COORD_W-1:0] M1 = -(COORD_W'(1 << COORD_FRAC_BITS));

   // pose history and latched target
   logic signed [COORD_W-1:0] x1_ff, x1_in, y1_ff, y1_in;
   logic signed [COORD_W-1:0] x2_ff, y2_ff, x2_in, y2_in;
   logic [BEARING_W-1:0]      a2_ff, a2_in;
   logic signed [COORD_W-1:0] tx_ff, tx_in, ty_ff, ty_in;
   logic                      found_ff, found_in;
   logic [BEARING_W-1:0]      pend_a_ff, pend_a_in;

   // CORDIC
   logic signed [TRIG_W-1:0]  cx_ff, cy_ff, cx_in, cy_in;
   logic signed [ZW-1:0]      cz_ff, cz_in;
   logic [1:0]                cq_ff, cq_in;
   logic signed [TRIG_W-1:0]  c1_ff, s1_ff, c2_ff, s2_ff, trig_c, trig_s;

   // products
   logic signed [WIDE_W-1:0]  b1_ff, b2_ff, det_ff, nx_ff, ny_ff, acc_ff;
   logic signed [WIDE_W-1:0]  r1_ff, r2_ff;
   logic signed [QUOT_W-1:0]  px_ff, py_ff;

   // divider
   logic [WIDE_W-1:0]         dn_ff, dd_ff, rem_ff, quo_ff;
   logic                      dneg_ff;

   logic signed [TRIG_W-1:0]  ma;
   logic signed [MUL_W-1:0]   mb;
   logic signed [PROD_W-1:0]  prod_full;
   logic signed [WIDE_W-1:0]  prod;
   logic [WIDE_W-1:0]         rem_sh;
   logic [ZW-1:0]             phase;
   logic [3:0]                it;
   logic signed [TRIG_W-1:0]  dx, dy;
   logic signed [WIDE_W-1:0]  q_signed, lim;
   logic                      box_ok;

   function automatic logic [WIDE_W-1:0] absw(input logic signed [WIDE_W-1:0] v);
      return v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
   endfunction

   function automatic logic [ZW-1:0] phase_of(input logic [BEARING_W-1:0] a);
      logic [63:0] w;
      begin
         w = (64'(a) & ((64'd1 << ANGLE_BITS) - 64'd1)) << SHIFT_L;
         return {1'b0, w[31:0]};
      end
   endfunction

   assign it     = cmd.step[3:0];
   assign dx     = cy_ff >>> it;
   assign dy     = cx_ff >>> it;
   assign phase  = phase_of(cmd.op == OP_LOAD ? bearing : a2_ff);

   always_comb begin
      unique case (cq_ff)
         2'd0: begin trig_c = cx_ff;  trig_s = cy_ff;  end
         2'd1: begin trig_c = -cy_ff; trig_s = cx_ff;  end
         2'd2: begin trig_c = -cx_ff; trig_s = -cy_ff; end
         default: begin trig_c = cy_ff; trig_s = -cx_ff; end
      endcase
   end

   // one multiply per step: a trig value times a pose, trig value, line term or offset of the point from a pose
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (cmd.step[3:0])
         4'd0:  begin ma = s1_ff; mb = MUL_W'(x1_ff); end
         4'd1:  begin ma = c1_ff; mb = MUL_W'(y1_ff); end
         4'd2:  begin ma = s2_ff; mb = MUL_W'(x2_ff); end
         4'd3:  begin ma = c2_ff; mb = MUL_W'(y2_ff); end
         4'd4:  begin ma = s2_ff; mb = MUL_W'(c1_ff); end
         4'd5:  begin ma = s1_ff; mb = MUL_W'(c2_ff); end
         4'd6:  begin ma = c2_ff; mb = MUL_W'(b1_ff); end
         4'd7:  begin ma = c1_ff; mb = MUL_W'(b2_ff); end
         4'd8:  begin ma = s2_ff; mb = MUL_W'(b1_ff); end
         4'd9:  begin ma = s1_ff; mb = MUL_W'(b2_ff); end
         4'd10: begin ma = s1_ff; mb = MUL_W'(px_ff - QUOT_W'(x1_ff)); end
         4'd11: begin ma = c1_ff; mb = MUL_W'(py_ff - QUOT_W'(y1_ff)); end
         4'd12: begin ma = s2_ff; mb = MUL_W'(px_ff - QUOT_W'(x2_ff)); end
         4'd13: begin ma = c2_ff; mb = MUL_W'(py_ff - QUOT_W'(y2_ff)); end
         default: begin ma = '0; mb = '0; end
      endcase
   end
   assign prod_full = ma * mb;
   assign prod   = WIDE_W'(prod_full);
   assign rem_sh = {rem_ff[WIDE_W-2:0], dn_ff[WIDE_W-1]};
   assign q_signed = dneg_ff ? -$signed(quo_ff) : $signed(quo_ff);
   assign lim    = WIDE_W'(residual_limit) << (COORD_FRAC_BITS + 8);
   assign box_ok = px_ff >= QUOT_W'(box_min) && px_ff <= QUOT_W'(box_max)
                && py_ff >= QUOT_W'(box_min) && py_ff <= QUOT_W'(box_max);

   always_comb begin
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; cq_in = cq_ff;
      if (cmd.op == OP_LOAD || cmd.op == OP_TRIG1) begin
         cx_in = CORDIC_X0;
         cy_in = '0;
         cz_in = ZW'(phase[29:0]);
         cq_in = phase[31:30];
      end else if (cmd.op == OP_CORDIC) begin
         if (!cz_ff[ZW-1]) begin
            cx_in = cx_ff - dx; cy_in = cy_ff + dy;
            cz_in = cz_ff - ZW'(atan_turn(it));
         end else begin
            cx_in = cx_ff + dx; cy_in = cy_ff - dy;
            cz_in = cz_ff + ZW'(atan_turn(it));
         end
      end
   end

   always_comb begin
      x1_in = x1_ff; y1_in = y1_ff; pend_a_in = pend_a_ff;
      x2_in = x2_ff; y2_in = y2_ff; a2_in = a2_ff;
      tx_in = tx_ff; ty_in = ty_ff; found_in = found_ff;
      if (cmd.op == OP_LOAD) begin
         // shift the held pose into history as the new one arrives
         x2_in = x1_ff; y2_in = y1_ff; a2_in = pend_a_ff;
         x1_in = pose_x; y1_in = pose_y; pend_a_in = bearing;
      end
      if (cmd.op == OP_DECIDE && box_ok && r1_ff < lim && r2_ff < lim) begin
         tx_in = COORD_W'(px_ff); ty_in = COORD_W'(py_ff); found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0; y1_ff <= M10; pend_a_ff <= '0;
         x2_ff <= '0; y2_ff <= M10; a2_ff <= '0;
         tx_ff <= M1; ty_ff <= M1; found_ff <= 1'b0;
      end else begin
         x1_ff <= x1_in; y1_ff <= y1_in; pend_a_ff <= pend_a_in;
         x2_ff <= x2_in; y2_ff <= y2_in; a2_ff <= a2_in;
         tx_ff <= tx_in; ty_ff <= ty_in; found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; cq_ff <= cq_in;
      unique case (cmd.op)
         OP_TRIG1: begin c1_ff <= trig_c; s1_ff <= trig_s; end
         OP_TRIG2: begin c2_ff <= trig_c; s2_ff <= trig_s; end
         OP_MUL: begin
            unique case (cmd.step[3:0])
               4'd0, 4'd2, 4'd10, 4'd12: acc_ff <= -prod;
               4'd1:  b1_ff  <= acc_ff + prod;
               4'd3:  b2_ff  <= acc_ff + prod;
               4'd4, 4'd6, 4'd8: acc_ff <= prod;
               4'd5:  det_ff <= acc_ff - prod;
               4'd7:  nx_ff  <= acc_ff - prod;
               4'd9:  ny_ff  <= acc_ff - prod;
               4'd11: r1_ff  <= acc_ff + prod;
               4'd13: r2_ff  <= acc_ff + prod;
               default: acc_ff <= acc_ff;
            endcase
         end
         OP_DIV_X, OP_DIV_Y: begin
            dn_ff   <= absw(cmd.op == OP_DIV_X ? nx_ff : ny_ff);
            dd_ff   <= absw(det_ff);
            dneg_ff <= (cmd.op == OP_DIV_X ? nx_ff[WIDE_W-1] : ny_ff[WIDE_W-1])
                       ^ det_ff[WIDE_W-1];
            rem_ff  <= '0;
            quo_ff  <= '0;
         end
         OP_DIV_STEP: begin
            dn_ff <= {dn_ff[WIDE_W-2:0], 1'b0};
            if (rem_sh >= dd_ff) begin
               rem_ff <= rem_sh - dd_ff;
               quo_ff <= {quo_ff[WIDE_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[WIDE_W-2:0], 1'b0};
            end
         end
         OP_DIV_DONE_X: px_ff <= QUOT_W'(q_signed);
         OP_DIV_DONE_Y: py_ff <= QUOT_W'(q_signed);
         default: ;
      endcase
   end

   assign status.det_zero = (det_ff == '0);
   assign status.box_ok   = box_ok;
   assign found    = found_ff;
   assign victim_x = tx_ff;
   assign victim_y = ty_ff;

   a_found_sticky: assert property (@(posedge clock) disable iff (reset)
      found_ff |=> found_ff) else $error("found flag cleared");
   a_latch_in_box: assert property (@(posedge clock) disable iff (reset)
      $rose(found_ff) |-> $past(box_ok)) else $error("latched outside box");
   a_hold_target: assert property (@(posedge clock) disable iff (reset)
      (cmd.op != OP_DECIDE) |=> $stable(tx_ff) && $stable(ty_ff))
      else $error("target moved outside decision");
endmodule
`default_nettype wire

FILE: hw/rtl/blt_ctrl.sv
// Controller: sequences one transaction through the datapath.
`default_nettype none
module blt_ctrl
   import blt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output dp_cmd_type         cmd,
   input  wire dp_status_type status
);
   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_COR1  = 9'b000000010,
      S_COR2  = 9'b000000100,
      S_TRIG2 = 9'b000001000,
      S_MUL   = 9'b000010000,
      S_DIVX  = 9'b000100000,
      S_DIVY  = 9'b001000000,
      S_RES   = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = OP_NONE;
      cmd.step = cnt_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = OP_LOAD; state_in = S_COR1; cnt_in = '0;
            end
         end
         S_COR1: begin
            if (cnt_ff == CNT_W'(CORDIC_ITERS)) begin
               cmd.op = OP_TRIG1; state_in = S_COR2; cnt_in = '0;
            end else begin
               cmd.op = OP_CORDIC; cnt_in = cnt_ff + 1'b1;
            end
         end
         S_COR2: begin
            if (cnt_ff == CNT_W'(CORDIC_ITERS)) begin
               cmd.op = OP_TRIG2; state_in = S_MUL; cnt_in = '0;
            end else begin
               cmd.op = OP_CORDIC; cnt_in = cnt_ff + 1'b1;
            end
         end
         S_TRIG2: state_in = S_MUL;
         S_MUL: begin
            cmd.op = OP_MUL; cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(9)) begin
               cnt_in = '0;
               state_in = S_DIVX;
            end
         end
         S_DIVX: begin
            if (status.det_zero) state_in = S_OUT;
            else if (cnt_ff == '0) begin cmd.op = OP_DIV_X; cnt_in = CNT_W'(1); end
            else if (cnt_ff == CNT_W'(WIDE_W + 1)) begin
               cmd.op = OP_DIV_DONE_X; cnt_in = '0; state_in = S_DIVY;
            end else begin cmd.op = OP_DIV_STEP; cnt_in = cnt_ff + 1'b1; end
         end
         S_DIVY: begin
            if (cnt_ff == '0) begin cmd.op = OP_DIV_Y; cnt_in = CNT_W'(1); end
            else if (cnt_ff == CNT_W'(WIDE_W + 1)) begin
               cmd.op = OP_DIV_DONE_Y; cnt_in = CNT_W'(10); state_in = S_RES;
            end else begin cmd.op = OP_DIV_STEP; cnt_in = cnt_ff + 1'b1; end
         end
         S_RES: begin
            if (cnt_ff == CNT_W'(14)) begin
               if (status.box_ok) cmd.op = OP_DECIDE;
               state_in = S_OUT;
            end else begin
               cmd.op = OP_MUL; cnt_in = cnt_ff + 1'b1;
            end
         end
         S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken while result pending");
   a_out_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_DIVX || state_ff == S_RES))
      else $error("result without work");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(WIDE_W + 1)) else $error("counter overrun");
endmodule
`default_nettype wire

FILE: test/bearing_line_triangulator_top_tb.sv
// Testbench: bearing line triangulator checked against its own fixed-point predictor.
`timescale 1ns / 1ps
module bearing_line_triangulator_top_tb;
   import blt_pkg::*;

   // Sightings and the position report, at the port widths.
   typedef struct {
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic [BEARING_W-1:0]      brg;
      bit                        typed;   // expected report written in the row
      logic                      fnd;
      logic signed [COORD_W-1:0] vx;
      logic signed [COORD_W-1:0] vy;
   } sighting_row_type;

   typedef struct {
      logic                      fnd;
      logic signed [COORD_W-1:0] vx;
      logic signed [COORD_W-1:0] vy;
   } fix_report_type;

   localparam int N_SWEEP = 16;
   localparam int RANDOM_PER_PHASE = 375;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [55:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [39:0]           rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index = CSR_BOX_MIN;
   logic [BOX_W-1:0]      csr_data = '0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int          mismatches = 0;

   // Predictor state: own copy of the registers and the previous sighting.
   logic [BOX_W-1:0]          box_lo, box_hi;
   logic [LIMIT_W-1:0]        res_lim;
   logic signed [COORD_W-1:0] last_x, last_y;
   logic [BEARING_W-1:0]      last_brg;
   fix_report_type            fix_now;

   fix_report_type pending_fixes[$];

   // Directed sweep: extremes, all four quadrant boundaries, parallel and
   // out-of-box lines, and two well-aimed pairs. The first row runs parallel
   // to the reset sighting, so its report can be written down directly.
   sighting_row_type sweep [N_SWEEP] = '{
      '{17'sd0,      17'sd2560,   16'h0000, 1'b1, 1'b0, -17'sd256, -17'sd256},
      '{17'sd25600,  17'sd0,      16'h4000, 1'b0, 1'b0, 17'sd0, 17'sd0},
      '{17'sd25600,  17'sd0,      16'h4000, 1'b0, 1'b0, 17'sd0, 17'sd0},
      '{-17'sd65536, -17'sd65536, 16'hFFFF, 1'b0, 1'b0, 17'sd0, 17'sd0},
      '{17'sd65535,  17'sd65535,  16'h8000, 1'b0, 1'b0, 17'sd0, 17'sd0},
      '{17'sd65535,  -17'sd65536, 16'hC000, 1'b0, 1'b0, 17'sd0, 17'sd0},
      '{17'sd0,      17'sd0,      16'h2000, 1'b0, 1'b0, 17'sd0, 17'sd0},
      '{17'sd51200,  17'sd0,      16'h6000, 1'b0, 1'b0, 17'sd0, 17'sd0},
      '{17'sd0,      17'sd65535,  16'h0001, 1'b0, 1'b0, 17'sd0, 17'sd0},
      '{-17'sd1,     -17'sd1,     16'h7FFF, 1'b0, 1'b0, 17'sd0, 17'sd0},
      '{17'sd0,      17'sd0,      16'hA000, 1'b0, 1'b0, 17'sd0, 17'sd0},
      '{17'sd256,    17'sd0,      16'hE000, 1'b0, 1'b0, 17'sd0, 17'sd0},
      '{-17'sd256,   -17'sd256,   16'h2000, 1'b0, 1'b0, 17'sd0, 17'sd0},
      '{17'sd1280,   17'sd1280,   16'h2000, 1'b0, 1'b0, 17'sd0, 17'sd0},
      '{17'sd12800,  17'sd2560,   16'h3FFF, 1'b0, 1'b0, 17'sd0, 17'sd0},
      '{17'sd2560,   17'sd12800,  16'h0000, 1'b0, 1'b0, 17'sd0, 17'sd0}
   };

   bearing_line_triangulator_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Cosine and sine scaled by 2^16: rotator in 2^-32 turn units, quadrant
   // taken from the top two phase bits.
   function automatic void bearing_trig(input logic [BEARING_W-1:0] brg,
                                        output longint c, output longint s);
      longint step_angle [CORDIC_ITERS] = '{
         536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
         10679838, 5340245, 2670163, 1335087, 667544, 333772,
         166886, 83443, 41722, 20861};
      logic [31:0] phase;
      longint      rx, ry, z, dx, dy;
      phase = {brg, 16'h0000};
      z  = longint'(phase[29:0]);
      rx = 39797;
      ry = 0;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         dx = ry >>> i;
         dy = rx >>> i;
         if (z >= 0) begin
            rx -= dx; ry += dy; z -= step_angle[i];
         end else begin
            rx += dx; ry -= dy; z += step_angle[i];
         end
      end
      case (phase[31:30])
         2'd0: begin c = rx;  s = ry;  end
         2'd1: begin c = -ry; s = rx;  end
         2'd2: begin c = -rx; s = -ry; end
         default: begin c = ry; s = -rx; end
      endcase
   endfunction

   // Intersect the new bearing line with the previous one; latch the point
   // when it sits in the box and both residuals stay under the limit.
   function automatic fix_report_type triangulate(input logic signed [COORD_W-1:0] nx,
                                                  input logic signed [COORD_W-1:0] ny,
                                                  input logic [BEARING_W-1:0] nb);
      longint x1, y1, x2, y2, c1, s1, c2, s2, b1, b2, det, qx, qy, lim, r1, r2;
      x1 = nx; y1 = ny; x2 = last_x; y2 = last_y;
      bearing_trig(nb, c1, s1);
      bearing_trig(last_brg, c2, s2);
      last_x = nx; last_y = ny; last_brg = nb;
      b1  = -s1 * x1 + c1 * y1;
      b2  = -s2 * x2 + c2 * y2;
      det = s2 * c1 - s1 * c2;
      if (det != 0) begin
         qx = (b1 * c2 - b2 * c1) / det;
         qy = (s2 * b1 - s1 * b2) / det;
         if (qx >= longint'(box_lo) && qx <= longint'(box_hi) &&
             qy >= longint'(box_lo) && qy <= longint'(box_hi)) begin
            lim = longint'(res_lim) <<< 16;
            r1  = -s1 * (qx - x1) + c1 * (qy - y1);
            r2  = -s2 * (qx - x2) + c2 * (qy - y2);
            if (r1 < lim && r2 < lim) begin
               fix_now.fnd = 1'b1;
               fix_now.vx  = qx[COORD_W-1:0];
               fix_now.vy  = qy[COORD_W-1:0];
            end
         end
      end
      return fix_now;
   endfunction

   // Bearing (fraction of a turn) from a pose towards a point.
   function automatic logic [BEARING_W-1:0] aim_at(input longint fx, input longint fy,
                                                   input longint tx, input longint ty);
      real turns;
      if (fx == tx && fy == ty)
         return BEARING_W'($urandom);
      turns = $atan2(real'(ty - fy), real'(tx - fx)) / (2.0 * 3.14159265358979);
      if (turns < 0.0)
         turns += 1.0;
      return BEARING_W'($rtoi(turns * 65536.0 + 0.5));
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // Hold the sighting until the block takes it, then queue its expected report.
   task automatic send_sighting(input sighting_row_type row);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, row.brg, row.py, row.px};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      if (row.typed) begin
         void'(triangulate(row.px, row.py, row.brg));
         pending_fixes.push_back('{row.fnd, row.vx, row.vy});
      end else begin
         pending_fixes.push_back(triangulate(row.px, row.py, row.brg));
      end
   endtask

   // Drop valid after the write and leave the port idle before the next one.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [BOX_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BOX_MIN:   box_lo = val;
         CSR_BOX_MAX:   box_hi = val;
         CSR_RES_LIMIT: res_lim = val[LIMIT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Let every queued report drain, then allow the datapath to settle.
   task automatic drain_reports();
      req_tvalid <= 1'b0;
      while (pending_fixes.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // Random sightings: mostly pairs aimed at a shared hidden target, some
   // noise so that every field bit and random bearings turn up.
   task automatic random_phase(input int n);
      sighting_row_type row;
      longint tx, ty, fx, fy;
      tx = 0; ty = 0;
      for (int k = 0; k < n; k++) begin
         row = '{default: '0};
         if ($urandom_range(99) < 70) begin
            if (k % 6 == 0) begin
               tx = $urandom_range(65535);
               ty = $urandom_range(65535);
            end
            if ($urandom_range(1) == 0) begin
               fx = tx + longint'($urandom_range(16000)) - 8000;
               fy = ty + longint'($urandom_range(16000)) - 8000;
               if (fx > 65535) fx = 65535;
               if (fy > 65535) fy = 65535;
            end else begin
               fx = longint'($urandom_range(131071)) - 65536;
               fy = longint'($urandom_range(131071)) - 65536;
            end
            row.px  = fx[COORD_W-1:0];
            row.py  = fy[COORD_W-1:0];
            row.brg = aim_at(fx, fy, tx, ty);
         end else begin
            row.px  = COORD_W'($urandom);
            row.py  = COORD_W'($urandom);
            row.brg = BEARING_W'($urandom);
         end
         send_sighting(row);
      end
   endtask

   // Receiver stalls change at the rising edge only.
   always @(posedge clock)
      rsp_tready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);

   // Check at the falling edge: the transaction completes at the next rising edge.
   always @(negedge clock) begin
      fix_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_fixes.size() == 0) begin
            report_mismatch("queued reports", 0, 1);
         end else begin
            want = pending_fixes.pop_front();
            if (rsp_tdata[0] !== want.fnd)
               report_mismatch("found", rsp_tdata[0], want.fnd);
            if (rsp_tdata[17:1] !== want.vx)
               report_mismatch("victim_x", $signed(rsp_tdata[17:1]), want.vx);
            if (rsp_tdata[34:18] !== want.vy)
               report_mismatch("victim_y", $signed(rsp_tdata[34:18]), want.vy);
         end
      end
   end

   initial begin
      box_lo  = BOX_MIN_RST;
      box_hi  = BOX_MAX_RST;
      res_lim = RES_LIMIT_RST;
      last_x  = '0;
      last_y  = -17'sd2560;
      last_brg = '0;
      fix_now = '{1'b0, -17'sd256, -17'sd256};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sweep at reset settings, no idling.
      for (int r = 0; r < N_SWEEP; r++)
         send_sighting(sweep[r]);
      drain_reports();

      // Widest box and loosest residual; no idling.
      write_reg(CSR_BOX_MIN, 16'd0);
      write_reg(CSR_BOX_MAX, 16'hFFFF);
      write_reg(CSR_RES_LIMIT, 16'd255);
      random_phase(RANDOM_PER_PHASE);
      drain_reports();

      // Reset settings back in place; sender mostly idle.
      write_reg(CSR_BOX_MIN, BOX_MIN_RST);
      write_reg(CSR_BOX_MAX, BOX_MAX_RST);
      write_reg(CSR_RES_LIMIT, 16'(RES_LIMIT_RST));
      send_idle_pct = 72;
      random_phase(RANDOM_PER_PHASE);
      drain_reports();

      // Zero residual limit: only negative residuals pass; receiver stalls.
      write_reg(CSR_RES_LIMIT, 16'd0);
      send_idle_pct  = 0;
      recv_stall_pct = 72;
      random_phase(RANDOM_PER_PHASE);
      drain_reports();

      // Inverted box accepts nothing, then a tight limit; both sides idle.
      write_reg(CSR_BOX_MIN, 16'd60000);
      write_reg(CSR_BOX_MAX, 16'd100);
      write_reg(CSR_RES_LIMIT, 16'd1);
      send_idle_pct  = 10;
      recv_stall_pct = 10;
      random_phase(RANDOM_PER_PHASE / 3);
      drain_reports();
      write_reg(CSR_BOX_MIN, 16'd0);
      write_reg(CSR_BOX_MAX, 16'd51200);
      random_phase(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 3);
      drain_reports();

      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/blt_pkg.sv
hw/rtl/blt_datapath.sv
hw/rtl/blt_ctrl.sv
hw/rtl/bearing_line_triangulator_top.sv
test/bearing_line_triangulator_top_tb.sv
